FILE: rtl/core/scope_edge_trigger_display_map_defines.svh
// Assertion macros shared by the scope edge trigger RTL.
`ifndef SCOPE_EDGE_TRIGGER_DISPLAY_MAP_DEFINES_SVH
`define SCOPE_EDGE_TRIGGER_DISPLAY_MAP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SETDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SETDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/setdm_pkg.sv
// Shared types and constants of the scope edge trigger block.
package setdm_pkg;

    localparam int BUFFER_DEPTH = 4096;
    localparam int EDGE_MARGIN  = 125;
    localparam int POS_ADJUST   = 5;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic signed [7:0] MIN_INIT = 8'sd126;
    localparam logic signed [7:0] MAX_INIT = -8'sd126;

    // j/3 as (j*683)>>11, exact for j below 1024
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    // x/255 as (x*263173)>>26, exact for x below 2^18
    localparam int DIV255_MUL   = 263173;
    localparam int DIV255_SHIFT = 26;
    localparam int PIX_ROUND    = 254;

    localparam logic [1:0] TRIG_RISE = 2'd0;
    localparam logic [1:0] TRIG_FALL = 2'd1;

    localparam logic [10:0] WIDTH_RESET  = 11'd800;
    localparam logic [9:0]  HEIGHT_RESET = 10'd400;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_READ   = 2'd2,
        KIND_SKIP   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_TRIG_MODE  = 3'd0,
        REG_TRIG_SRC   = 3'd1,
        REG_INTERLEAVE = 3'd2,
        REG_WIDTH      = 3'd3,
        REG_HEIGHT     = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_DRAIN,
        ST_RADDR,
        ST_RDATA,
        ST_RDIV,
        ST_DONE
    } t_bstate;

    typedef struct packed {
        t_kind              kind;
        logic signed [7:0]  ch1_sample;
        logic signed [7:0]  ch2_sample;
        logic               ch1_comp;
        logic               ch2_comp;
        logic [9:0]         point_index;
    } t_item;

    typedef struct packed {
        logic [1:0]  trig_mode;
        logic        trig_src;
        logic        interleave;
        logic [10:0] width;
        logic [9:0]  height;
    } t_cfg;

endpackage

FILE: rtl/core/setdm_channels.sv
// Valid/ready channel interfaces for sample items and results.
interface setdm_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic signed [7:0] ch1_sample;
    logic signed [7:0] ch2_sample;
    logic              ch1_comp;
    logic              ch2_comp;
    logic [9:0]        point_index;

    modport source (output valid, kind, ch1_sample, ch2_sample, ch1_comp, ch2_comp,
                    point_index, input ready);
    modport sink (input valid, kind, ch1_sample, ch2_sample, ch1_comp, ch2_comp,
                  point_index, output ready);
endinterface

interface setdm_out_if;
    logic              valid;
    logic              ready;
    logic              found;
    logic [11:0]       trigger_position;
    logic signed [7:0] ch1_max;
    logic signed [7:0] ch1_min;
    logic signed [7:0] ch2_max;
    logic signed [7:0] ch2_min;
    logic [9:0]        ch1_pixel;
    logic [9:0]        ch2_pixel;

    modport source (output valid, found, trigger_position, ch1_max, ch1_min, ch2_max,
                    ch2_min, ch1_pixel, ch2_pixel, input ready);
    modport sink (input valid, found, trigger_position, ch1_max, ch1_min, ch2_max,
                  ch2_min, ch1_pixel, ch2_pixel, output ready);
endinterface

FILE: rtl/core/setdm_front.sv
// Front end: accept item beats, drop unused kinds, queue the rest for the back end.
module setdm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    setdm_in_if.sink              i_smp,
    output setdm_pkg::t_item      o_head,
    output logic                  o_head_v,
    input  logic                  i_pop
);
    localparam int QAW = $clog2(setdm_pkg::QUEUE_DEPTH);

    setdm_pkg::t_item r_q [setdm_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;
    logic             w_acc, w_push;
    setdm_pkg::t_item w_item;

    assign i_smp.ready = (r_cnt != (QAW+1)'(setdm_pkg::QUEUE_DEPTH));
    assign w_acc       = i_smp.valid && i_smp.ready;
    // unused kind is taken and dropped
    assign w_push      = w_acc && (i_smp.kind != setdm_pkg::KIND_SKIP);

    always_comb begin
        w_item.kind        = setdm_pkg::t_kind'(i_smp.kind);
        w_item.ch1_sample  = i_smp.ch1_sample;
        w_item.ch2_sample  = i_smp.ch2_sample;
        w_item.ch1_comp    = i_smp.ch1_comp;
        w_item.ch2_comp    = i_smp.ch2_comp;
        w_item.point_index = i_smp.point_index;
    end

    assign o_head   = r_q[r_rd];
    assign o_head_v = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(w_push) - (QAW+1)'(i_pop);
        end
    end
endmodule

FILE: rtl/core/setdm_back.sv
// Back end: sample store, trigger scan, window min/max sweep and pixel mapping.
module setdm_back #(
    parameter int BUFFER_DEPTH = setdm_pkg::BUFFER_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  setdm_pkg::t_cfg       i_cfg,
    input  setdm_pkg::t_item      i_head,
    input  logic                  i_head_v,
    output logic                  o_pop,
    setdm_out_if.source           o_res
);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int IW = AW + 2;
    localparam int SW = AW + 3;
    localparam int OW = 12;

    setdm_pkg::t_bstate r_state, n_state;

    logic [7:0] r_ch1_mem [BUFFER_DEPTH];
    logic [7:0] r_ch2_mem [BUFFER_DEPTH];
    logic       r_cp1_mem [BUFFER_DEPTH];
    logic       r_cp2_mem [BUFFER_DEPTH];

    logic [AW:0]    r_wp;
    logic [AW-1:0]  r_ws;
    logic [AW-1:0]  w_wa;

    logic signed [IW-1:0] r_k, r_dk;
    logic                 r_dv;
    logic [5:0]           r_sh;
    logic [2:0]           r_fill;
    logic                 r_cbit;

    logic [10:0]   r_j;
    logic [OW-1:0] r_off;
    logic [1:0]    r_m3;
    logic          r_sv;
    logic [7:0]    r_s1, r_s2;

    logic signed [7:0] r_mx1, r_mn1, r_mx2, r_mn2;
    logic              r_found, r_is_read;
    logic [17:0]       r_num1, r_num2;
    logic [9:0]        r_q1, r_q2;

    logic                 w_is_load, w_is_search, w_is_read;
    logic                 w_scan_go;
    logic [9:0]           w_half;
    logic signed [IW-1:0] w_lo, w_hi, w_i, w_pos;
    logic [5:0]           w_sh, w_want;
    logic                 w_full, w_hit, w_miss, w_scan_end;
    logic                 w_setup, w_setup_found;
    logic [AW-1:0]        w_setup_pos;
    logic [SW-1:0]        w_sum, w_ws_ext;
    logic [AW-1:0]        w_pt_addr;
    logic [19:0]          w_d3;
    logic [8:0]           w_q3;
    logic [10:0]          w_q3x3;
    logic [1:0]           w_r3;
    logic [OW-1:0]        w_roff;
    logic [17:0]          w_t1, w_t2;
    logic [36:0]          w_p1, w_p2;
    logic                 w_out_free;
    logic signed [7:0]    w_s1, w_s2;

    assign w_is_load   = i_head_v && (i_head.kind == setdm_pkg::KIND_LOAD);
    assign w_is_search = i_head_v && (i_head.kind == setdm_pkg::KIND_SEARCH);
    assign w_is_read   = i_head_v && (i_head.kind == setdm_pkg::KIND_READ);
    assign w_out_free  = !o_res.valid || o_res.ready;

    // Scan bounds
    assign w_half = i_cfg.width[10:1];
    assign w_lo   = IW'(w_half) + IW'(setdm_pkg::EDGE_MARGIN);
    assign w_hi   = IW'(BUFFER_DEPTH) - IW'(w_half) - IW'(setdm_pkg::EDGE_MARGIN);
    assign w_scan_go = ((i_cfg.trig_mode == setdm_pkg::TRIG_RISE) ||
                        (i_cfg.trig_mode == setdm_pkg::TRIG_FALL)) && (w_lo < w_hi);

    // Six-bit window of comparator bits, oldest in the top bit
    assign w_sh   = {r_sh[4:0], r_cbit};
    assign w_want = (i_cfg.trig_mode == setdm_pkg::TRIG_FALL) ? 6'b111000 : 6'b000111;
    assign w_full = (r_fill >= 3'd5);
    assign w_i    = r_dk - IW'(3);
    assign w_miss = r_dv && w_full && (w_i >= w_hi);
    assign w_hit  = r_dv && w_full && !w_miss && (w_sh == w_want);
    assign w_scan_end = (r_state == setdm_pkg::ST_SCAN) && (w_hit || w_miss);
    assign w_pos  = w_i - IW'(w_half) + IW'(setdm_pkg::POS_ADJUST)
                    - (i_cfg.interleave ? IW'(setdm_pkg::EDGE_MARGIN) : IW'(0));

    assign w_setup = w_scan_end ||
                     ((r_state == setdm_pkg::ST_IDLE) && w_is_search && !w_scan_go);
    assign w_setup_found = w_scan_end && w_hit;
    assign w_setup_pos   = w_setup_found ? w_pos[AW-1:0] : AW'(w_half);

    // Display point address, clamped to the last position
    assign w_ws_ext  = SW'(r_ws);
    assign w_sum     = w_ws_ext + SW'(r_off);
    assign w_pt_addr = (w_sum >= SW'(BUFFER_DEPTH)) ? AW'(BUFFER_DEPTH - 1) : w_sum[AW-1:0];

    // Interleave offset of a read point: (j/3)*4 + j%3
    assign w_d3   = i_head.point_index * 10'(setdm_pkg::DIV3_MUL);
    assign w_q3   = w_d3[19:setdm_pkg::DIV3_SHIFT];
    assign w_q3x3 = {1'b0, w_q3, 1'b0} + {2'b00, w_q3};
    assign w_r3   = 2'(i_head.point_index - {1'b0, w_q3x3[8:0]});
    assign w_roff = i_cfg.interleave ? ({1'b0, w_q3, 2'b00} + OW'(w_r3))
                                     : OW'(i_head.point_index);

    assign w_wa = (r_wp >= (AW+1)'(BUFFER_DEPTH)) ? AW'(BUFFER_DEPTH - 1) : r_wp[AW-1:0];

    assign w_s1 = r_s1;
    assign w_s2 = r_s2;
    assign w_t1 = r_num1 + 18'(setdm_pkg::PIX_ROUND);
    assign w_t2 = r_num2 + 18'(setdm_pkg::PIX_ROUND);
    assign w_p1 = w_t1 * 19'(setdm_pkg::DIV255_MUL);
    assign w_p2 = w_t2 * 19'(setdm_pkg::DIV255_MUL);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            setdm_pkg::ST_IDLE: begin
                if (w_is_search) begin
                    if (w_scan_go) begin
                        n_state = setdm_pkg::ST_SCAN;
                    end else begin
                        n_state = (i_cfg.width == '0) ? setdm_pkg::ST_DONE
                                                      : setdm_pkg::ST_SWEEP;
                    end
                end else if (w_is_read) begin
                    n_state = setdm_pkg::ST_RADDR;
                end
            end
            setdm_pkg::ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = (i_cfg.width == '0) ? setdm_pkg::ST_DONE
                                                  : setdm_pkg::ST_SWEEP;
                end
            end
            setdm_pkg::ST_SWEEP: begin
                if (r_j == i_cfg.width - 11'd1) begin
                    n_state = setdm_pkg::ST_DRAIN;
                end
            end
            setdm_pkg::ST_DRAIN: n_state = setdm_pkg::ST_DONE;
            setdm_pkg::ST_RADDR: n_state = setdm_pkg::ST_RDATA;
            setdm_pkg::ST_RDATA: n_state = setdm_pkg::ST_RDIV;
            setdm_pkg::ST_RDIV:  n_state = setdm_pkg::ST_DONE;
            setdm_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = setdm_pkg::ST_IDLE;
                end
            end
            default: n_state = setdm_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        o_pop = (r_state == setdm_pkg::ST_IDLE) && i_head_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= setdm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sample store
    always_ff @(posedge i_clk) begin
        if ((r_state == setdm_pkg::ST_IDLE) && w_is_load) begin
            r_ch1_mem[w_wa] <= i_head.ch1_sample;
            r_ch2_mem[w_wa] <= i_head.ch2_sample;
            r_cp1_mem[w_wa] <= i_head.ch1_comp;
            r_cp2_mem[w_wa] <= i_head.ch2_comp;
        end
        r_s1 <= r_ch1_mem[w_pt_addr];
        r_s2 <= r_ch2_mem[w_pt_addr];
        if (i_cfg.trig_src) begin
            r_cbit <= r_cp2_mem[r_k[AW-1:0]];
        end else begin
            r_cbit <= r_cp1_mem[r_k[AW-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_ws        <= '0;
            r_dv        <= 1'b0;
            r_sv        <= 1'b0;
            o_res.valid <= 1'b0;
        end else begin
            r_dv <= (r_state == setdm_pkg::ST_SCAN) && !w_scan_end;
            r_sv <= (r_state == setdm_pkg::ST_SWEEP);
            if ((r_state == setdm_pkg::ST_IDLE) && w_is_load &&
                (r_wp < (AW+1)'(BUFFER_DEPTH))) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_setup) begin
                r_wp <= '0;
                r_ws <= w_setup_pos;
            end
            if (o_res.valid && o_res.ready) begin
                o_res.valid <= 1'b0;
            end
            if ((r_state == setdm_pkg::ST_DONE) && w_out_free) begin
                o_res.valid <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            setdm_pkg::ST_IDLE: begin
                r_k    <= w_lo - IW'(2);
                r_fill <= '0;
                r_sh   <= '0;
                r_off  <= w_roff;
                r_is_read <= w_is_read;
            end
            setdm_pkg::ST_SCAN: begin
                r_k  <= r_k + IW'(1);
                r_dk <= r_k;
                if (r_dv) begin
                    r_sh <= w_sh;
                    if (!w_full) begin
                        r_fill <= r_fill + 3'd1;
                    end
                end
            end
            setdm_pkg::ST_SWEEP: begin
                r_j <= r_j + 11'd1;
                if (i_cfg.interleave && (r_m3 == 2'd2)) begin
                    r_off <= r_off + OW'(2);
                end else begin
                    r_off <= r_off + OW'(1);
                end
                r_m3 <= (r_m3 == 2'd2) ? 2'd0 : r_m3 + 2'd1;
            end
            setdm_pkg::ST_RDATA: begin
                r_num1 <= {~r_s1[7], r_s1[6:0]} * i_cfg.height;
                r_num2 <= {~r_s2[7], r_s2[6:0]} * i_cfg.height;
            end
            setdm_pkg::ST_RDIV: begin
                r_q1 <= w_p1[setdm_pkg::DIV255_SHIFT +: 10];
                r_q2 <= w_p2[setdm_pkg::DIV255_SHIFT +: 10];
            end
            default: begin
            end
        endcase

        if (w_setup) begin
            r_found <= w_setup_found;
            r_j     <= '0;
            r_off   <= '0;
            r_m3    <= '0;
            r_mx1   <= setdm_pkg::MAX_INIT;
            r_mn1   <= setdm_pkg::MIN_INIT;
            r_mx2   <= setdm_pkg::MAX_INIT;
            r_mn2   <= setdm_pkg::MIN_INIT;
        end else if (r_sv) begin
            if (w_s1 > r_mx1) r_mx1 <= w_s1;
            if (w_s1 < r_mn1) r_mn1 <= w_s1;
            if (w_s2 > r_mx2) r_mx2 <= w_s2;
            if (w_s2 < r_mn2) r_mn2 <= w_s2;
        end

        if ((r_state == setdm_pkg::ST_DONE) && w_out_free) begin
            o_res.trigger_position <= w_ws_ext[11:0];
            if (r_is_read) begin
                o_res.found     <= 1'b0;
                o_res.ch1_max   <= '0;
                o_res.ch1_min   <= '0;
                o_res.ch2_max   <= '0;
                o_res.ch2_min   <= '0;
                o_res.ch1_pixel <= i_cfg.height - r_q1;
                o_res.ch2_pixel <= i_cfg.height - r_q2;
            end else begin
                o_res.found     <= r_found;
                o_res.ch1_max   <= r_mx1;
                o_res.ch1_min   <= r_mn1;
                o_res.ch2_max   <= r_mx2;
                o_res.ch2_min   <= r_mn2;
                o_res.ch1_pixel <= '0;
                o_res.ch2_pixel <= '0;
            end
        end
    end
endmodule

FILE: rtl/core/scope_edge_trigger_display_map.sv
// Scope edge trigger and display mapper: top level with register port.
// Items enter on i_smp (valid/ready) and results leave on o_res (valid/ready).
// A load beat writes both samples and comparator bits at the write pointer
// and gives no result; a load drains from the queue one per cycle while no search or read is in progress.
// A search scans the selected comparator bits one position per cycle from
// W/2+125 on, then sweeps the W display points one per cycle for min/max.
// A read maps one display point to pixel rows in steps (address, store
// read, scale multiply, divide-by-255 multiply, output register).
// A four-entry queue parts the accepting front end from the back end, so
// loads keep being taken while a search runs, until the queue fills.
// The output register holds a result until taken; a stalled receiver stops
// the back end only, and the queue keeps accepting until full.
// Registers on the APB port: trigger mode, trigger source, interleave,
// display width, display height, at byte offsets 0, 4, 8, 12, 16.
// Reset (synchronous, active low) clears pointers, queue and output valid and
// loads register defaults; the sample store keeps its contents.
`include "scope_edge_trigger_display_map_defines.svh"

module scope_edge_trigger_display_map #(
    parameter int BUFFER_DEPTH = setdm_pkg::BUFFER_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    setdm_in_if.sink    i_smp,
    setdm_out_if.source o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    setdm_pkg::t_cfg   r_cfg;
    setdm_pkg::t_item  w_head;
    logic              w_head_v;
    logic              w_pop;
    logic              w_wr;
    setdm_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = setdm_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_mode  <= setdm_pkg::TRIG_RISE;
            r_cfg.trig_src   <= 1'b0;
            r_cfg.interleave <= 1'b0;
            r_cfg.width      <= setdm_pkg::WIDTH_RESET;
            r_cfg.height     <= setdm_pkg::HEIGHT_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                setdm_pkg::REG_TRIG_MODE:  r_cfg.trig_mode  <= pwdata[1:0];
                setdm_pkg::REG_TRIG_SRC:   r_cfg.trig_src   <= pwdata[0];
                setdm_pkg::REG_INTERLEAVE: r_cfg.interleave <= pwdata[0];
                setdm_pkg::REG_WIDTH:      r_cfg.width      <= pwdata[10:0];
                setdm_pkg::REG_HEIGHT:     r_cfg.height     <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            setdm_pkg::REG_TRIG_MODE:  prdata = 32'(r_cfg.trig_mode);
            setdm_pkg::REG_TRIG_SRC:   prdata = 32'(r_cfg.trig_src);
            setdm_pkg::REG_INTERLEAVE: prdata = 32'(r_cfg.interleave);
            setdm_pkg::REG_WIDTH:      prdata = 32'(r_cfg.width);
            setdm_pkg::REG_HEIGHT:     prdata = 32'(r_cfg.height);
            default:                   prdata = '0;
        endcase
    end

    setdm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smp    (i_smp),
        .o_head   (w_head),
        .o_head_v (w_head_v),
        .i_pop    (w_pop)
    );

    setdm_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (w_head),
        .i_head_v (w_head_v),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );

    `SETDM_ASSERT_NOW(a_pop_needs_item, i_clk, i_rst_n, w_pop, w_head_v, "pop from empty queue")
    `SETDM_ASSERT_NOW(a_search_no_pixel, i_clk, i_rst_n, o_res.valid && o_res.found, (o_res.ch1_pixel == 10'd0) && (o_res.ch2_pixel == 10'd0), "search result carries pixel data")
    `SETDM_ASSERT_NEXT(a_width_write, i_clk, i_rst_n, w_wr && (w_idx == setdm_pkg::REG_WIDTH), r_cfg.width == $past(pwdata[10:0]), "display width write lost")
endmodule
